@@ hdl/fnmf_pkg.sv @@
// fnmf_pkg: shared types, constants and helpers of the four-neighbour mean filter
// used by fnmf_ctrl, fnmf_dpath, fnmf_div and the top level
`default_nettype none

package fnmf_pkg;

  localparam int unsigned DEF_MAX_SIDE     = 64;
  localparam int unsigned DEF_SAMPLE_WIDTH = 16;
  localparam int unsigned DEF_FRAC_BITS    = 8;

  localparam int unsigned CFG_W      = 7;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned MEAN_W     = 24;
  localparam int unsigned RESET_SIDE = 4;
  localparam int unsigned DIV_BITS   = 8;
  localparam int unsigned CNT_W      = 3;

  localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  typedef logic [1:0] slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic cfg_wr;
    logic pick;
    logic read;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pend_any;
    logic nb_left;
    logic rd_pend;
    logic div_done;
    logic out_free;
  } status_t;

  // row buffer slots cycle through 0, 1, 2
  function automatic slot_t slot_inc(slot_t s);
    return (s == 2'd2) ? 2'd0 : slot_t'(s + 2'd1);
  endfunction

  function automatic slot_t slot_dec(slot_t s);
    return (s == 2'd0) ? 2'd2 : slot_t'(s - 2'd1);
  endfunction

endpackage

`default_nettype wire

@@ hdl/fnmf_div.sv @@
// fnmf_div: restoring divider by a small count, DIV_BITS quotient bits per cycle while step is high
// depends on fnmf_pkg
`default_nettype none

module fnmf_div #(
  parameter int unsigned NUM_W = 26
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic                      step,
  input  logic [NUM_W-1:0]          num,
  input  logic [fnmf_pkg::CNT_W-1:0] den,
  output logic [NUM_W-1:0]          quot,
  output logic                      done
);
  import fnmf_pkg::*;

  localparam int unsigned STEPS = (NUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned PAD_W = STEPS * DIV_BITS;
  localparam int unsigned SC_W  = $clog2(STEPS + 1);

  logic [PAD_W-1:0] work_r, work_nxt;
  logic [1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0] den_r;
  logic [SC_W-1:0]  left_r;

  always_comb begin
    logic [PAD_W-1:0] w;
    logic [2:0]       t;
    logic [1:0]       rm;
    w  = work_r;
    rm = rem_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {rm, w[PAD_W-1]};
      w = {w[PAD_W-2:0], 1'b0};
      if (t >= den_r) begin
        t    = t - den_r;
        w[0] = 1'b1;
      end
      rm = t[1:0];
    end
    work_nxt = w;
    rem_nxt  = rm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (load) begin
      left_r <= SC_W'(STEPS);
    end else if (step) begin
      left_r <= left_r - SC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work_r <= PAD_W'(num);
      rem_r  <= '0;
      den_r  <= den;
    end else if (step) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign quot = work_r[NUM_W-1:0];
  assign done = (left_r == '0);

endmodule

`default_nettype wire

@@ hdl/fnmf_dpath.sv @@
// fnmf_dpath: position counters, three row buffers, neighbour sum, rounding and output word
// depends on fnmf_pkg and fnmf_div
`default_nettype none

module fnmf_dpath #(
  parameter int unsigned MAX_SIDE      = fnmf_pkg::DEF_MAX_SIDE,
  parameter int unsigned SAMPLE_WIDTH  = fnmf_pkg::DEF_SAMPLE_WIDTH,
  parameter int unsigned FRACTION_BITS = fnmf_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fnmf_pkg::cmd_t                    cmd,
  output fnmf_pkg::status_t                 status,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  input  logic [fnmf_pkg::CFG_W-1:0]        cfg_matrix_side,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [fnmf_pkg::IDX_W-1:0]        out_row,
  output logic [fnmf_pkg::IDX_W-1:0]        out_col,
  output logic signed [fnmf_pkg::MEAN_W-1:0] out_neighbor_mean,
  output logic                              out_last_of_matrix
);
  import fnmf_pkg::*;

  localparam int unsigned POS_W     = $clog2(MAX_SIDE);
  localparam int unsigned SUM_W     = SAMPLE_WIDTH + 2;
  localparam int unsigned NUM_W     = SUM_W + FRACTION_BITS;
  localparam int unsigned RESET_EFF = (RESET_SIDE > MAX_SIDE) ? MAX_SIDE : RESET_SIDE;
  localparam logic [POS_W-1:0] RESET_LAST = POS_W'(RESET_EFF - 1);

  localparam int unsigned NB_UP    = 0;
  localparam int unsigned NB_DOWN  = 1;
  localparam int unsigned NB_LEFT  = 2;
  localparam int unsigned NB_RIGHT = 3;
  localparam int unsigned NB_SELF  = 4;
  localparam int unsigned NB_N     = 5;

  localparam int unsigned RES_ABOVE  = 0;
  localparam int unsigned RES_LEFT   = 1;
  localparam int unsigned RES_CORNER = 2;
  localparam int unsigned RES_N      = 3;

  // position of the next sample
  logic [POS_W-1:0] side_last_r, side_last_nxt;
  logic [POS_W-1:0] row_r, col_r;
  slot_t            slot_r;
  logic [POS_W-1:0] cur_row, cur_col;
  slot_t            cur_slot;
  logic             at_last_row, at_last_col;
  logic [RES_N-1:0] pend_r, pend_new, pend_sel;

  // item and target cell
  logic [POS_W-1:0] item_row_r, item_col_r;
  slot_t            item_slot_r;
  logic [POS_W-1:0] tgt_row_r, tgt_col_r, tgt_row_nxt, tgt_col_nxt;
  slot_t            tgt_slot_r, tgt_slot_nxt;
  logic             tgt_last_r, tgt_last_nxt;
  logic [NB_N-1:0]  nbm_r, nbm_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // row buffers and accumulation
  logic [SAMPLE_WIDTH-1:0] row_store_r [3][MAX_SIDE];
  slot_t                   rd_slot;
  logic [POS_W-1:0]        rd_col;
  logic                    rd_issue;
  logic [SAMPLE_WIDTH-1:0] rd_data_r;
  logic                    rd_pend_r;
  logic [SUM_W-1:0]        acc_r;

  // division and output
  logic             neg_r;
  logic [SUM_W-1:0] mag;
  logic [NUM_W-1:0] num, quot;
  logic             div_done, big;
  logic [MEAN_W-1:0] low, mean;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic              out_last_r;

  always_comb begin
    logic [31:0] v;
    v = 32'(cfg_matrix_side);
    if (v == 32'd0) begin
      side_last_nxt = '0;
    end else if (v > 32'(MAX_SIDE)) begin
      side_last_nxt = POS_W'(MAX_SIDE - 1);
    end else begin
      side_last_nxt = POS_W'(v - 32'd1);
    end
  end

  always_comb begin
    logic pos_ok;
    pos_ok   = (row_r <= side_last_r) && (col_r <= side_last_r);
    cur_row  = pos_ok ? row_r : '0;
    cur_col  = pos_ok ? col_r : '0;
    cur_slot = pos_ok ? slot_r : 2'd0;
    at_last_row = (cur_row == side_last_r);
    at_last_col = (cur_col == side_last_r);
    pend_new[RES_ABOVE]  = (cur_row != '0);
    pend_new[RES_LEFT]   = at_last_row && (cur_col != '0);
    pend_new[RES_CORNER] = at_last_row && at_last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_last_r <= RESET_LAST;
      row_r       <= '0;
      col_r       <= '0;
      slot_r      <= 2'd0;
    end else if (cmd.cfg_wr) begin
      side_last_r <= side_last_nxt;
      row_r       <= '0;
      col_r       <= '0;
      slot_r      <= 2'd0;
    end else if (cmd.accept) begin
      if (at_last_col) begin
        col_r <= '0;
        if (at_last_row) begin
          row_r  <= '0;
          slot_r <= 2'd0;
        end else begin
          row_r  <= cur_row + POS_W'(1);
          slot_r <= slot_inc(cur_slot);
        end
      end else begin
        row_r  <= cur_row;
        col_r  <= cur_col + POS_W'(1);
        slot_r <= cur_slot;
      end
    end
  end

  // target selection: cell above first, then left, then the corner
  always_comb begin
    logic up, down, left, right;
    pend_sel     = '0;
    tgt_row_nxt  = item_row_r;
    tgt_col_nxt  = item_col_r;
    tgt_slot_nxt = item_slot_r;
    tgt_last_nxt = 1'b0;
    if (pend_r[RES_ABOVE]) begin
      pend_sel[RES_ABOVE] = 1'b1;
      tgt_row_nxt  = item_row_r - POS_W'(1);
      tgt_slot_nxt = slot_dec(item_slot_r);
    end else if (pend_r[RES_LEFT]) begin
      pend_sel[RES_LEFT] = 1'b1;
      tgt_col_nxt = item_col_r - POS_W'(1);
    end else begin
      pend_sel[RES_CORNER] = 1'b1;
      tgt_last_nxt = 1'b1;
    end
    up    = (tgt_row_nxt != '0);
    down  = (tgt_row_nxt != side_last_r);
    left  = (tgt_col_nxt != '0);
    right = (tgt_col_nxt != side_last_r);
    nbm_nxt[NB_UP]    = up;
    nbm_nxt[NB_DOWN]  = down;
    nbm_nxt[NB_LEFT]  = left;
    nbm_nxt[NB_RIGHT] = right;
    nbm_nxt[NB_SELF]  = !(up || down || left || right);
    cnt_nxt = CNT_W'(up) + CNT_W'(down) + CNT_W'(left) + CNT_W'(right);
    if (cnt_nxt == '0) begin
      cnt_nxt = CNT_W'(1);
    end
  end

  always_comb begin
    rd_slot = tgt_slot_r;
    rd_col  = tgt_col_r;
    if (nbm_r[NB_UP]) begin
      rd_slot = slot_dec(tgt_slot_r);
    end else if (nbm_r[NB_DOWN]) begin
      rd_slot = slot_inc(tgt_slot_r);
    end else if (nbm_r[NB_LEFT]) begin
      rd_col = tgt_col_r - POS_W'(1);
    end else if (nbm_r[NB_RIGHT]) begin
      rd_col = tgt_col_r + POS_W'(1);
    end
    rd_issue = cmd.read && (nbm_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      nbm_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_issue;
      if (cmd.accept) begin
        pend_r <= pend_new;
      end else if (cmd.pick) begin
        pend_r <= pend_r & ~pend_sel;
      end
      if (cmd.pick) begin
        nbm_r <= nbm_nxt;
      end else if (rd_issue) begin
        nbm_r <= nbm_r & (nbm_r - NB_N'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_row_r  <= cur_row;
      item_col_r  <= cur_col;
      item_slot_r <= cur_slot;
    end
    if (cmd.pick) begin
      tgt_row_r  <= tgt_row_nxt;
      tgt_col_r  <= tgt_col_nxt;
      tgt_slot_r <= tgt_slot_nxt;
      tgt_last_r <= tgt_last_nxt;
      cnt_r      <= cnt_nxt;
      acc_r      <= '0;
    end else if (cmd.read && rd_pend_r) begin
      acc_r <= acc_r + {{2{rd_data_r[SAMPLE_WIDTH-1]}}, rd_data_r};
    end
    if (cmd.div_load) begin
      neg_r <= acc_r[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_store_r[cur_slot][cur_col] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data_r <= row_store_r[rd_slot][rd_col];
    end
  end

  // magnitude scaled to fixed point, plus half the count for rounding
  always_comb begin
    mag = acc_r[SUM_W-1] ? SUM_W'(-acc_r) : acc_r;
    num = (NUM_W'(mag) << FRACTION_BITS) + NUM_W'(cnt_r >> 1);
  end

  fnmf_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cmd.div_load),
    .step  (cmd.div_step),
    .num   (num),
    .den   (cnt_r),
    .quot  (quot),
    .done  (div_done)
  );

  // saturate to the signed output range
  always_comb begin
    big = ((quot >> (MEAN_W - 1)) != '0);
    low = MEAN_W'(quot);
    if (neg_r) begin
      mean = big ? MEAN_MIN : MEAN_W'(-low);
    end else begin
      mean = big ? MEAN_MAX : low;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r  <= IDX_W'(tgt_row_r);
      out_col_r  <= IDX_W'(tgt_col_r);
      out_mean_r <= mean;
      out_last_r <= tgt_last_r;
    end
  end

  assign status.pend_any = (pend_r != '0);
  assign status.nb_left  = (nbm_r != '0);
  assign status.rd_pend  = rd_pend_r;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_row            = out_row_r;
  assign out_col            = out_col_r;
  assign out_neighbor_mean  = out_mean_r;
  assign out_last_of_matrix = out_last_r;

endmodule

`default_nettype wire

@@ hdl/fnmf_ctrl.sv @@
// fnmf_ctrl: sequencer for register writes, accept, target pick, neighbour reads, division and output load
// depends on fnmf_pkg
`default_nettype none

module fnmf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              cfg_valid,
  input  fnmf_pkg::status_t status,
  output fnmf_pkg::cmd_t    cmd,
  output logic              in_stall,
  output logic              cfg_ready
);
  import fnmf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !cfg_valid) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        state_nxt = status.pend_any ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        if (!(status.nb_left || status.rd_pend)) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) state_nxt = ST_PICK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // a register write goes first, the input word waits while cfg_valid is high
        in_stall   = cfg_valid;
        cfg_ready  = 1'b1;
        cmd.accept = in_valid && !cfg_valid;
        cmd.cfg_wr = cfg_valid;
      end
      ST_PICK: begin
        cmd.pick = status.pend_any;
      end
      ST_READ: begin
        cmd.read     = status.nb_left || status.rd_pend;
        cmd.div_load = !(status.nb_left || status.rd_pend);
      end
      ST_DIV: begin
        cmd.div_step = !status.div_done;
      end
      ST_OUT: begin
        cmd.out_load = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/four_neighbor_mean_filter.sv @@
// four_neighbor_mean_filter: top level, mean of the up/down/left/right neighbours of each cell
// depends on fnmf_pkg, fnmf_ctrl, fnmf_dpath and fnmf_div
//
//   port group  handshake            word
//   in_         in_valid / in_stall  in_sample
//   out_        out_valid / out_stall out_row, out_col, out_neighbor_mean, out_last_of_matrix
//   cfg_        cfg_valid / cfg_ready cfg_matrix_side
//
// one word is taken, then each of its 0 to 3 results reads n samples (1 to 4, the neighbours
// or the cell itself) one at a time from the row buffer, divides their sum by n in the
// divider, DIV_BITS quotient bits per step, and loads the output register; a word without
// result goes straight back to idle.
// synchronous active-low reset restarts the matrix at cell (0,0) with a side of 4.
// a stalled output holds its word and the sequencer waits at the output register.
`default_nettype none

module four_neighbor_mean_filter #(
  parameter int unsigned MAX_SIDE      = fnmf_pkg::DEF_MAX_SIDE,
  parameter int unsigned SAMPLE_WIDTH  = fnmf_pkg::DEF_SAMPLE_WIDTH,
  parameter int unsigned FRACTION_BITS = fnmf_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fnmf_pkg::IDX_W-1:0]         out_row,
  output logic [fnmf_pkg::IDX_W-1:0]         out_col,
  output logic signed [fnmf_pkg::MEAN_W-1:0] out_neighbor_mean,
  output logic                               out_last_of_matrix,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fnmf_pkg::CFG_W-1:0]         cfg_matrix_side
);
  import fnmf_pkg::*;

  cmd_t    cmd;
  status_t status;

  fnmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  fnmf_dpath #(
    .MAX_SIDE      (MAX_SIDE),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_sample          (in_sample),
    .cfg_matrix_side    (cfg_matrix_side),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_row            (out_row),
    .out_col            (out_col),
    .out_neighbor_mean  (out_neighbor_mean),
    .out_last_of_matrix (out_last_of_matrix)
  );

  // a taken word keeps the input closed for at least the next cycle
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a word was taken");

  // the bottom-right cell sits on the diagonal
  a_last_on_diagonal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_matrix |-> out_row == out_col)
    else $error("last cell flag off the diagonal");

  // results appear only while a word is being worked on
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded while idle");

endmodule

`default_nettype wire

@@ dv/tb_four_neighbor_mean_filter.sv @@
// tb_four_neighbor_mean_filter: self-checking testbench of the four-neighbour mean filter
// predicts every result word from its own row store and compares it with the block's output
// depends on fnmf_pkg and four_neighbor_mean_filter
module tb_four_neighbor_mean_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE_LIMIT    = fnmf_pkg::DEF_MAX_SIDE;
  localparam int SAMPLE_W      = fnmf_pkg::DEF_SAMPLE_WIDTH;
  localparam int FRAC_W        = fnmf_pkg::DEF_FRAC_BITS;
  localparam int IDX_W         = fnmf_pkg::IDX_W;
  localparam int MEAN_W        = fnmf_pkg::MEAN_W;
  localparam int CFG_W         = fnmf_pkg::CFG_W;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int RANDOM_ITEMS  = 130;
  localparam int REPORT_LIMIT  = 10;
  localparam longint MEAN_TOP  = 64'sd8388607;
  localparam longint MEAN_BOT  = -64'sd8388608;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [MEAN_W-1:0] mean;
    logic                     last;
  } mean_cell_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [IDX_W-1:0]           out_row;
  logic [IDX_W-1:0]           out_col;
  logic signed [MEAN_W-1:0]   out_neighbor_mean;
  logic                       out_last_of_matrix;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           cfg_matrix_side = '0;

  // predictor state
  logic signed [SAMPLE_W-1:0] row_rings [3][SIDE_LIMIT];
  logic [CFG_W-1:0]           side_reg = CFG_W'(fnmf_pkg::RESET_SIDE);
  int                         next_row = 0;
  int                         next_col = 0;
  mean_cell_t                 pending_cells [$];

  int mismatch_count = 0;
  int sent_count     = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;
  bit hold_req       = 1'b0;

  four_neighbor_mean_filter u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_row            (out_row),
    .out_col            (out_col),
    .out_neighbor_mean  (out_neighbor_mean),
    .out_last_of_matrix (out_last_of_matrix),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_matrix_side    (cfg_matrix_side)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int active_side();
    if (side_reg == '0) return 1;
    if (int'(side_reg) > SIDE_LIMIT) return SIDE_LIMIT;
    return int'(side_reg);
  endfunction

  function automatic logic signed [MEAN_W-1:0] rounded_mean(longint sum, longint cnt);
    longint num;
    longint mag;
    longint q;
    longint v;
    num = sum * (64'sd1 <<< FRAC_W);
    mag = (num < 0) ? -num : num;
    q = (mag + cnt / 2) / cnt;
    if (q > MEAN_TOP + 1) q = MEAN_TOP + 1;
    v = (num < 0) ? -q : q;
    if (v > MEAN_TOP) v = MEAN_TOP;
    if (v < MEAN_BOT) v = MEAN_BOT;
    return v[MEAN_W-1:0];
  endfunction

  function automatic logic signed [MEAN_W-1:0] neighbour_mean(int r, int c, int side);
    longint sum;
    longint cnt;
    sum = 0;
    cnt = 0;
    if (r >= 1) begin
      sum += row_rings[(r - 1) % 3][c];
      cnt++;
    end
    if (r + 1 < side) begin
      sum += row_rings[(r + 1) % 3][c];
      cnt++;
    end
    if (c >= 1) begin
      sum += row_rings[r % 3][c - 1];
      cnt++;
    end
    if (c + 1 < side) begin
      sum += row_rings[r % 3][c + 1];
      cnt++;
    end
    if (cnt == 0) begin
      sum = row_rings[r % 3][c];
      cnt = 1;
    end
    return rounded_mean(sum, cnt);
  endfunction

  function automatic void queue_cell(int r, int c, logic signed [MEAN_W-1:0] m, logic last);
    mean_cell_t cell_word;
    cell_word.row  = r[IDX_W-1:0];
    cell_word.col  = c[IDX_W-1:0];
    cell_word.mean = m;
    cell_word.last = last;
    pending_cells.push_back(cell_word);
  endfunction

  function automatic void predict_sample(logic signed [SAMPLE_W-1:0] s);
    int side;
    int r;
    int c;
    side = active_side();
    r = next_row;
    c = next_col;
    if (r >= side || c >= side) begin
      r = 0;
      c = 0;
    end
    row_rings[r % 3][c] = s;
    if (side == 1) begin
      queue_cell(0, 0, rounded_mean(longint'(s), 1), 1'b1);
      next_row = 0;
      next_col = 0;
      return;
    end
    if (r >= 1) queue_cell(r - 1, c, neighbour_mean(r - 1, c, side), 1'b0);
    if (r == side - 1) begin
      if (c >= 1) queue_cell(r, c - 1, neighbour_mean(r, c - 1, side), 1'b0);
      if (c == side - 1) queue_cell(r, c, neighbour_mean(r, c, side), 1'b1);
    end
    c++;
    if (c >= side) begin
      c = 0;
      r++;
      if (r >= side) r = 0;
    end
    next_row = r;
    next_col = c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: v = {1'b1, {(SAMPLE_W-1){1'b0}}};
      2: v = SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    predict_sample(s);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_random(input int n);
    repeat (n) send_sample(pick_sample());
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
  endtask

  task automatic write_side(input logic [CFG_W-1:0] side);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_matrix_side <= side;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    side_reg = side;
    next_row = 0;
    next_col = 0;
  endtask

  task automatic test_reset_side();
    send_random(fnmf_pkg::RESET_SIDE * fnmf_pkg::RESET_SIDE);
  endtask

  task automatic test_single_cell();
    write_side(CFG_W'(1));
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    send_sample(16'sh0001);
  endtask

  task automatic test_side_zero();
    write_side(CFG_W'(0));
    send_sample(16'sh04d2);
    send_sample(16'sh8000);
  endtask

  task automatic test_corners_extremes();
    write_side(CFG_W'(2));
    repeat (4) send_sample(16'sh7fff);
    repeat (4) send_sample(16'sh8000);
  endtask

  task automatic test_edge_rounding();
    write_side(CFG_W'(3));
    send_sample(16'sh0001);
    send_sample(16'shffff);
    send_sample(16'sh0002);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0007);
    send_sample(16'shfffb);
    send_sample(16'sh0003);
    send_sample(16'sh7fff);
  endtask

  task automatic test_large_side();
    write_side(CFG_W'(SIDE_LIMIT));
    send_random(80);
    // above the maximum, restarts mid-matrix
    write_side({CFG_W{1'b1}});
    send_random(130);
  endtask

  task automatic test_sender_pause();
    write_side(CFG_W'(4));
    send_random(7);
    wait_results();
    send_random(9);
  endtask

  task automatic test_output_hold();
    write_side(CFG_W'(5));
    hold_req = 1'b1;
    send_random(25);
  endtask

  task automatic test_random_matrices();
    int first;
    int count;
    int side;
    logic [CFG_W-1:0] side_val;
    first = sent_count;
    while (sent_count - first < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: side_val = CFG_W'(1);
        1: side_val = CFG_W'(0);
        2: side_val = CFG_W'($urandom_range(SIDE_LIMIT + 1, (1 << CFG_W) - 1));
        3: side_val = CFG_W'($urandom_range(7, 8));
        default: side_val = CFG_W'($urandom_range(2, 6));
      endcase
      write_side(side_val);
      side = active_side();
      if (side == SIDE_LIMIT || $urandom_range(0, 4) == 0) begin
        count = (side == SIDE_LIMIT) ? $urandom_range(1, 100)
                                     : $urandom_range(1, (side * side > 1) ? side * side - 1 : 1);
      end else begin
        count = side * side * $urandom_range(1, 2);
      end
      send_random(count);
    end
  endtask

  initial begin : receiver
    stall_mode_t mode;
    int span;
    int phase;
    mode  = STALL_NONE;
    span  = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          span = $urandom_range(10, 80);
        end
        span--;
        phase++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (phase % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    mean_cell_t got;
    mean_cell_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.row  = out_row;
      got.col  = out_col;
      got.mean = out_neighbor_mean;
      got.last = out_last_of_matrix;
      if (pending_cells.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result word: row %0d col %0d mean %0d last %0b",
                   got.row, got.col, got.mean, got.last);
      end else begin
        want = pending_cells.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: want r%0d c%0d m%0d l%0b, got r%0d c%0d m%0d l%0b",
                     want.row, want.col, want.mean, want.last,
                     got.row, got.col, got.mean, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("four_neighbor_mean_filter test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_side();
    test_single_cell();
    test_side_zero();
    test_corners_extremes();
    test_edge_rounding();
    test_large_side();
    test_sender_pause();
    test_output_hold();
    test_random_matrices();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatch_count += pending_cells.size();
    if (mismatch_count == 0) begin
      $display("four_neighbor_mean_filter test passed");
    end else begin
      $display("four_neighbor_mean_filter test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/fnmf_pkg.sv
hdl/fnmf_div.sv
hdl/fnmf_dpath.sv
hdl/fnmf_ctrl.sv
hdl/four_neighbor_mean_filter.sv
dv/tb_four_neighbor_mean_filter.sv
